// ===== src/flacmh_pkg.sv =====
// ----------------------------------------------------------------------------
// FLAC metadata header parser package
// Shared constants, status codes and the divider request and response types.
// ----------------------------------------------------------------------------
package flacmh_pkg;

  localparam int DIV_W = 42;
  localparam int INFO_BYTES = 18;
  localparam int ADDR_W = 3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_MARKER = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_SKIP_EOF = 3'd3;
  localparam logic [2:0] ST_NO_INFO = 3'd4;

  localparam logic [6:0] KIND_STREAMINFO = 7'd0;
  localparam logic [6:0] KIND_SEEKTABLE = 7'd3;

  localparam logic REG_FILE_SIZE = 1'b0;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [7:0] MARKER_0 = 8'h66;
  localparam logic [7:0] MARKER_1 = 8'h4C;
  localparam logic [7:0] MARKER_2 = 8'h61;
  localparam logic [7:0] MARKER_3 = 8'h43;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [7:0] marker_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0: val = MARKER_0;
      2'd1: val = MARKER_1;
      2'd2: val = MARKER_2;
      default: val = MARKER_3;
    endcase
    return val;
  endfunction

endpackage

// ===== src/flac_metadata_header_parser.sv =====
// ----------------------------------------------------------------------------
// FLAC metadata header parser
// Checks the stream marker, walks the metadata blocks and reports the
// STREAMINFO facts, the metadata length and the bitrate.
// ----------------------------------------------------------------------------
// The parser takes one file byte per clock cycle while it walks the marker,
// the block headers and the block bodies, and the only stall during that
// walk comes from a result still waiting at the output. When the last block
// ends, a good stream needs two divisions on one shared restoring divider
// that produces one quotient bit per cycle, or only one division when less
// than one second of audio makes the second division unnecessary, and no
// byte is taken until the final result is loaded. Errors, and results whose
// bitrate is zero without dividing, come out at once.
// ----------------------------------------------------------------------------
module flac_metadata_header_parser
  import flacmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_file,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [19:0]       sample_rate,
  output logic [3:0]        channel_count,
  output logic [5:0]        bits_per_sample,
  output logic [15:0]       min_block_size,
  output logic [15:0]       max_block_size,
  output logic [23:0]       min_frame_size,
  output logic [23:0]       max_frame_size,
  output logic [31:0]       total_samples,
  output logic [31:0]       metadata_length,
  output logic [31:0]       bitrate_kbps
);

  typedef enum logic [1:0] {
    PH_MARKER,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIV1,
    SQ_MUL,
    SQ_CHK,
    SQ_DIV2,
    SQ_EMIT
  } seq_t;

  logic [31:0] file_size;
  phase_t      phase;
  seq_t        seq;
  logic [1:0]  mcount;
  logic [23:0] hdr;
  logic [23:0] bib;
  logic [23:0] blk_len;
  logic [6:0]  blk_kind;
  logic        last_flag;
  logic [31:0] pos;
  logic [31:0] meta_total;
  logic        seen;
  logic [7:0]  info [INFO_BYTES];
  logic [7:0]  info_cur [INFO_BYTES];
  logic [DIV_W-1:0] den;
  logic [31:0] rate_q;

  phase_t      phase_next;
  logic [1:0]  mcount_next;
  logic [23:0] hdr_next;
  logic [23:0] bib_next;
  logic [23:0] len_next;
  logic [6:0]  kind_next;
  logic        last_next;
  logic [31:0] pos_next;
  logic [31:0] meta_next;
  logic        seen_next;

  logic        in_acc;
  logic        cfg_wr;
  logic        out_free;
  logic        info_clr;
  logic        info_wr;
  logic        err_go;
  logic [2:0]  err_code;
  logic        fin_go;
  logic        do_div;
  logic        load_ok;
  logic        load_err;
  logic [31:0] hdr_word;
  logic [31:0] pos_inc;
  logic [32:0] skip_sum;
  logic [23:0] bib_inc;

  logic [19:0] f_rate;
  logic [3:0]  f_chan;
  logic [5:0]  f_bps;
  logic [31:0] f_total;
  logic [34:0] num;

  div_req_t div_req;
  div_rsp_t div_rsp;

  flacmh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FILE_SIZE) ? file_size : 32'd0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILE_SIZE);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (seq != SQ_IDLE) || !out_free;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    phase_next = phase;
    mcount_next = mcount;
    hdr_next = hdr;
    bib_next = bib;
    len_next = blk_len;
    kind_next = blk_kind;
    last_next = last_flag;
    pos_next = pos;
    meta_next = meta_total;
    seen_next = seen;
    info_clr = 1'b0;
    info_wr = 1'b0;
    err_go = 1'b0;
    err_code = ST_OK;
    fin_go = 1'b0;
    hdr_word = {hdr, data_byte};
    pos_inc = pos + 32'd1;
    skip_sum = {1'b0, pos_inc} + {9'b0, hdr_word[23:0]};
    bib_inc = bib + 24'd1;
    if (in_acc) begin
      if (restart) begin
        phase_next = PH_MARKER;
        mcount_next = '0;
        hdr_next = '0;
        bib_next = '0;
        len_next = '0;
        kind_next = '0;
        last_next = 1'b0;
        pos_next = '0;
        meta_next = '0;
        seen_next = 1'b0;
        info_clr = 1'b1;
      end else if (phase != PH_DONE) begin
        if (end_of_file) begin
          err_go = 1'b1;
          err_code = ST_TRUNCATED;
        end else begin
          pos_next = pos_inc;
          unique case (phase)
            PH_MARKER: begin
              if (data_byte != marker_byte(mcount)) begin
                err_go = 1'b1;
                err_code = ST_BAD_MARKER;
              end else if (mcount == 2'd3) begin
                mcount_next = '0;
                meta_next = 32'd4;
                phase_next = PH_HEADER;
                bib_next = '0;
                hdr_next = '0;
              end else begin
                mcount_next = mcount + 2'd1;
              end
            end
            PH_HEADER: begin
              hdr_next = hdr_word[23:0];
              bib_next = bib_inc;
              if (bib == 24'd3) begin
                last_next = hdr_word[31];
                kind_next = hdr_word[30:24];
                len_next = hdr_word[23:0];
                meta_next = meta_total + {8'b0, hdr_word[23:0]} + 32'd4;
                bib_next = '0;
                if (hdr_word[30:24] == KIND_STREAMINFO && hdr_word[23:0] == 24'd0) begin
                  err_go = 1'b1;
                  err_code = ST_TRUNCATED;
                end else if (hdr_word[30:24] != KIND_STREAMINFO &&
                             hdr_word[30:24] != KIND_SEEKTABLE &&
                             skip_sum >= {1'b0, file_size}) begin
                  err_go = 1'b1;
                  err_code = ST_SKIP_EOF;
                end else begin
                  if (hdr_word[30:24] == KIND_STREAMINFO) begin
                    info_clr = 1'b1;
                    seen_next = 1'b1;
                  end
                  if (hdr_word[23:0] == 24'd0) begin
                    if (hdr_word[31]) begin
                      fin_go = 1'b1;
                    end else begin
                      hdr_next = '0;
                    end
                  end else begin
                    phase_next = PH_BODY;
                  end
                end
              end
            end
            PH_BODY: begin
              info_wr = (blk_kind == KIND_STREAMINFO);
              bib_next = bib_inc;
              if (bib_inc >= blk_len) begin
                if (last_flag) begin
                  fin_go = 1'b1;
                end else begin
                  phase_next = PH_HEADER;
                  bib_next = '0;
                  hdr_next = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    if (fin_go && !seen_next) begin
      err_go = 1'b1;
      err_code = ST_NO_INFO;
    end
  end

  // The byte of the current transfer is part of the captured facts already.
  always_comb begin
    for (int i = 0; i < INFO_BYTES; i++) begin
      info_cur[i] = (info_wr && bib == 24'(i)) ? data_byte : info[i];
    end
  end

  always_comb begin
    f_rate = {info_cur[10], info_cur[11], info_cur[12][7:4]};
    f_chan = {1'b0, info_cur[12][3:1]} + 4'd1;
    f_bps = {1'b0, info_cur[12][0], info_cur[13][7:4]} + 6'd1;
    f_total = {info_cur[14], info_cur[15], info_cur[16], info_cur[17]};
    num = {file_size - meta_total, 3'b000};
  end

  always_comb begin
    do_div = fin_go && seen_next && (file_size >= meta_next) && (f_rate != 20'd0);
    load_ok = (fin_go && seen_next && !do_div) || (seq == SQ_EMIT && out_free);
    load_err = err_go;
  end

  always_comb begin
    div_req.start = do_div || (seq == SQ_CHK && den != '0);
    if (seq == SQ_CHK) begin
      div_req.dividend = {{(DIV_W - 35){1'b0}}, num};
      div_req.divisor = den;
    end else begin
      div_req.dividend = {{(DIV_W - 32){1'b0}}, f_total};
      div_req.divisor = {{(DIV_W - 20){1'b0}}, f_rate};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
      phase <= PH_MARKER;
      seq <= SQ_IDLE;
      mcount <= '0;
      hdr <= '0;
      bib <= '0;
      blk_len <= '0;
      blk_kind <= '0;
      last_flag <= 1'b0;
      pos <= '0;
      meta_total <= '0;
      seen <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < INFO_BYTES; i++) begin
        info[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        file_size <= pwdata;
      end

      phase <= (err_go || fin_go) ? PH_DONE : phase_next;
      mcount <= mcount_next;
      hdr <= hdr_next;
      bib <= bib_next;
      blk_len <= len_next;
      blk_kind <= kind_next;
      last_flag <= last_next;
      pos <= pos_next;
      meta_total <= meta_next;
      seen <= seen_next;

      if (info_clr) begin
        for (int i = 0; i < INFO_BYTES; i++) begin
          info[i] <= '0;
        end
      end else if (info_wr && bib < 24'(INFO_BYTES)) begin
        info[bib[4:0]] <= data_byte;
      end

      unique case (seq)
        SQ_IDLE: begin
          if (do_div) begin
            seq <= SQ_DIV1;
          end
        end
        SQ_DIV1: begin
          if (div_rsp.done) begin
            seq <= SQ_MUL;
          end
        end
        SQ_MUL: begin
          den <= div_rsp.quotient[31:0] * MS_PER_S;
          seq <= SQ_CHK;
        end
        SQ_CHK: begin
          if (den == '0) begin
            rate_q <= '0;
            seq <= SQ_EMIT;
          end else begin
            seq <= SQ_DIV2;
          end
        end
        SQ_DIV2: begin
          if (div_rsp.done) begin
            rate_q <= div_rsp.quotient[31:0];
            seq <= SQ_EMIT;
          end
        end
        SQ_EMIT: begin
          if (out_free) begin
            seq <= SQ_IDLE;
          end
        end
        default: begin
          seq <= SQ_IDLE;
        end
      endcase

      if (load_err) begin
        out_valid <= 1'b1;
        status <= err_code;
        sample_rate <= '0;
        channel_count <= '0;
        bits_per_sample <= '0;
        min_block_size <= '0;
        max_block_size <= '0;
        min_frame_size <= '0;
        max_frame_size <= '0;
        total_samples <= '0;
        metadata_length <= '0;
        bitrate_kbps <= '0;
      end else if (load_ok) begin
        out_valid <= 1'b1;
        status <= ST_OK;
        sample_rate <= f_rate;
        channel_count <= f_chan;
        bits_per_sample <= f_bps;
        min_block_size <= {info_cur[0], info_cur[1]};
        max_block_size <= {info_cur[2], info_cur[3]};
        min_frame_size <= {info_cur[4], info_cur[5], info_cur[6]};
        max_frame_size <= {info_cur[7], info_cur[8], info_cur[9]};
        total_samples <= f_total;
        metadata_length <= meta_next;
        bitrate_kbps <= (seq == SQ_EMIT) ? rate_q : 32'd0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (seq == SQ_DIV1 || seq == SQ_DIV2))
    else $error("Divider finished outside a division step.");

  a_seq_after_parse: assert property (@(posedge clk) disable iff (rst)
    (seq != SQ_IDLE) |-> (phase == PH_DONE))
    else $error("Bitrate sequence runs while parsing is still active.");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bib < blk_len))
    else $error("Body byte count passed the block length.");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (bitrate_kbps == 32'd0 && metadata_length == 32'd0))
    else $error("Error transfer carries nonzero stream facts.");

endmodule

// ===== src/flacmh_div.sv =====
// ----------------------------------------------------------------------------
// FLAC metadata header parser divider
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module flacmh_div
  import flacmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;

  always_comb begin
    shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
    diff = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= CNT_W'(DIV_W);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem <= diff[DIV_W] ? shifted : diff;
      quo <= {quo[DIV_W-2:0], ~diff[DIV_W]};
      cnt <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

// ===== tb/tb_flac_metadata_header_parser.sv =====
// ----------------------------------------------------------------------------
// FLAC metadata header parser testbench
// Feeds marker, block header and block body bytes with random gaps and
// output stalls, predicts each result from its parser model or the plan of
// a directed byte, and checks each field under several file_size settings.
// ----------------------------------------------------------------------------
module tb_flac_metadata_header_parser;
  import flacmh_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 300;
  localparam int SETTLE = 100;
  localparam logic [7:0] FLAC_TAG [4] = '{MARKER_0, MARKER_1, MARKER_2, MARKER_3};

  typedef enum logic [1:0] {AT_MARKER, AT_HEADER, AT_BODY, AT_DONE} walk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       restart;
    logic       typed;
    logic [2:0] want_status;
  } stim_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] rate;
    logic [3:0]  chans;
    logic [5:0]  bps;
    logic [15:0] min_blk;
    logic [15:0] max_blk;
    logic [23:0] min_frm;
    logic [23:0] max_frm;
    logic [31:0] total;
    logic [31:0] meta_len;
    logic [31:0] kbps;
  } header_facts_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        end_of_file = 1'b0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [19:0] sample_rate;
  logic [3:0]  channel_count;
  logic [5:0]  bits_per_sample;
  logic [15:0] min_block_size;
  logic [15:0] max_block_size;
  logic [23:0] min_frame_size;
  logic [23:0] max_frame_size;
  logic [31:0] total_samples;
  logic [31:0] metadata_length;
  logic [31:0] bitrate_kbps;

  flac_metadata_header_parser dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_file(end_of_file), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .sample_rate(sample_rate), .channel_count(channel_count),
    .bits_per_sample(bits_per_sample), .min_block_size(min_block_size),
    .max_block_size(max_block_size), .min_frame_size(min_frame_size),
    .max_frame_size(max_frame_size), .total_samples(total_samples),
    .metadata_length(metadata_length), .bitrate_kbps(bitrate_kbps)
  );

  always #2 clk = ~clk;

  stim_item_t    stim_q[$];
  stim_item_t    build_q[$];
  header_facts_t facts_q[$];
  stim_item_t    cur_item = '0;
  stim_item_t    plan [0:24];

  int  fails = 0;
  int  items_made = 0;
  int  bytes_taken = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  int  cyc = 0;
  int  held = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  // Parser state as predicted from the byte stream.
  logic [31:0] fsize = '0;
  walk_e       walk = AT_MARKER;
  logic [1:0]  tag_idx = '0;
  logic [31:0] hdr = '0;
  logic [23:0] blk_byte = '0;
  logic [23:0] blk_len = '0;
  logic [6:0]  blk_kind = '0;
  logic        blk_last = 1'b0;
  logic [31:0] pos = '0;
  logic [31:0] meta_sum = '0;
  logic        si_seen = 1'b0;
  logic [7:0]  info [0:17] = '{default: 8'h00};

  function automatic bit give_up(input logic [2:0] code, output header_facts_t r);
    r = '0;
    r.status = code;
    walk = AT_DONE;
    return 1'b1;
  endfunction

  function automatic bit stream_facts(output header_facts_t r);
    logic [63:0] num, secs, den;
    if (!si_seen) return give_up(ST_NO_INFO, r);
    r = '0;
    r.status = ST_OK;
    r.rate = {info[10], info[11], info[12][7:4]};
    r.chans = 4'(info[12][3:1]) + 4'd1;
    r.bps = {1'b0, info[12][0], info[13][7:4]} + 6'd1;
    r.min_blk = {info[0], info[1]};
    r.max_blk = {info[2], info[3]};
    r.min_frm = {info[4], info[5], info[6]};
    r.max_frm = {info[7], info[8], info[9]};
    r.total = {info[14], info[15], info[16], info[17]};
    r.meta_len = meta_sum;
    if (fsize >= meta_sum && r.rate != 0) begin
      num = 64'(fsize - meta_sum) * 64'd8;
      secs = 64'(r.total / 32'(r.rate));
      den = secs * 64'(MS_PER_S);
      if (den != 0) r.kbps = 32'(num / den);
    end
    walk = AT_DONE;
    return 1'b1;
  endfunction

  function automatic bit close_block(output header_facts_t r);
    r = '0;
    if (blk_last) return stream_facts(r);
    walk = AT_HEADER;
    blk_byte = '0;
    hdr = '0;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input stim_item_t it, output header_facts_t r);
    r = '0;
    if (it.restart) begin
      walk = AT_MARKER;
      tag_idx = '0;
      hdr = '0;
      blk_byte = '0;
      blk_len = '0;
      blk_kind = '0;
      blk_last = 1'b0;
      pos = '0;
      meta_sum = '0;
      si_seen = 1'b0;
      foreach (info[i]) info[i] = 8'h00;
      return 1'b0;
    end
    if (walk == AT_DONE) return 1'b0;
    if (it.eof) return give_up(ST_TRUNCATED, r);
    pos = pos + 32'd1;
    case (walk)
      AT_MARKER: begin
        if (it.data != FLAC_TAG[tag_idx]) return give_up(ST_BAD_MARKER, r);
        if (tag_idx == 2'd3) begin
          tag_idx = '0;
          meta_sum = 32'd4;
          walk = AT_HEADER;
          blk_byte = '0;
          hdr = '0;
        end else begin
          tag_idx = tag_idx + 2'd1;
        end
        return 1'b0;
      end
      AT_HEADER: begin
        hdr = {hdr[23:0], it.data};
        blk_byte = blk_byte + 24'd1;
        if (blk_byte < 24'd4) return 1'b0;
        blk_last = hdr[31];
        blk_kind = hdr[30:24];
        blk_len = hdr[23:0];
        meta_sum = meta_sum + 32'(blk_len) + 32'd4;
        blk_byte = '0;
        if (blk_kind == KIND_STREAMINFO) begin
          if (blk_len == 0) return give_up(ST_TRUNCATED, r);
          foreach (info[i]) info[i] = 8'h00;
          si_seen = 1'b1;
        end else if (blk_kind != KIND_SEEKTABLE) begin
          if ({1'b0, pos} + 33'(blk_len) >= {1'b0, fsize}) return give_up(ST_SKIP_EOF, r);
        end
        if (blk_len == 0) return close_block(r);
        walk = AT_BODY;
        return 1'b0;
      end
      AT_BODY: begin
        if (blk_kind == KIND_STREAMINFO && blk_byte < 24'd18) info[blk_byte] = it.data;
        blk_byte = blk_byte + 24'd1;
        if (blk_byte >= blk_len) return close_block(r);
        return 1'b0;
      end
      default: begin
        walk = AT_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_facts(input header_facts_t want, input header_facts_t got);
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("sample_rate", 32'(want.rate), 32'(got.rate));
    check_field("channel_count", 32'(want.chans), 32'(got.chans));
    check_field("bits_per_sample", 32'(want.bps), 32'(got.bps));
    check_field("min_block_size", 32'(want.min_blk), 32'(got.min_blk));
    check_field("max_block_size", 32'(want.max_blk), 32'(got.max_blk));
    check_field("min_frame_size", 32'(want.min_frm), 32'(got.min_frm));
    check_field("max_frame_size", 32'(want.max_frm), 32'(got.max_frm));
    check_field("total_samples", want.total, got.total);
    check_field("metadata_length", want.meta_len, got.meta_len);
    check_field("bitrate_kbps", want.kbps, got.kbps);
  endtask

  always @(posedge clk) begin : feed
    stim_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stim_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 13)) begin
        nxt = stim_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.data;
        end_of_file <= nxt.eof;
        restart <= nxt.restart;
        cur_item <= nxt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && held < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      held <= held + 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk) begin : watch
    header_facts_t want, got;
    bit made;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        made = parse_byte(cur_item, want);
        if (cur_item.typed) begin
          want = '0;
          want.status = cur_item.want_status;
          made = 1'b1;
        end
        if (made) facts_q.push_back(want);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        got.status = status;
        got.rate = sample_rate;
        got.chans = channel_count;
        got.bps = bits_per_sample;
        got.min_blk = min_block_size;
        got.max_blk = max_block_size;
        got.min_frm = min_frame_size;
        got.max_frm = max_frame_size;
        got.total = total_samples;
        got.meta_len = metadata_length;
        got.kbps = bitrate_kbps;
        if (facts_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          fails++;
        end else begin
          check_facts(facts_q.pop_front(), got);
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_file_size(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FILE_SIZE, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fsize = v;
    settings_used++;
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_valid || facts_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_item(input logic [7:0] d, input logic e, input logic r);
    stim_item_t it;
    it = '0;
    it.data = d;
    it.eof = e;
    it.restart = r;
    build_q.push_back(it);
  endtask

  task automatic add_header(input bit is_last, input logic [6:0] kind,
                            input logic [23:0] len);
    add_item({is_last, kind}, 1'b0, 1'b0);
    add_item(len[23:16], 1'b0, 1'b0);
    add_item(len[15:8], 1'b0, 1'b0);
    add_item(len[7:0], 1'b0, 1'b0);
  endtask

  task automatic add_stream();
    int r, n_blk, si_at, si_dup, cut, len, pick;
    logic [7:0] si [0:17];
    logic [6:0] kind;
    build_q.delete();
    r = $urandom_range(0, 99);
    add_item(8'($urandom), 1'($urandom), 1'b1);
    if (r >= 90) begin
      repeat ($urandom_range(1, 8))
        add_item(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end else if (r >= 80) begin
      foreach (FLAC_TAG[i]) add_item(FLAC_TAG[i], 1'b0, 1'b0);
      add_header(1'($urandom), 7'($urandom), 24'($urandom));
      repeat ($urandom_range(0, 6)) add_item(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 1) == 1) add_item(8'($urandom), 1'b1, 1'b0);
    end else if (r >= 77) begin
      add_item(FLAC_TAG[0], 1'b0, 1'b0);
      add_item(FLAC_TAG[1], 1'b0, 1'b0);
      add_item(8'($urandom), 1'b0, 1'b0);
    end else begin
      foreach (FLAC_TAG[i]) add_item(FLAC_TAG[i], 1'b0, 1'b0);
      n_blk = $urandom_range(1, 4);
      si_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n_blk - 1);
      si_dup = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n_blk - 1) : -1;
      for (int b = 0; b < n_blk; b++) begin
        if (b == si_at || b == si_dup) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) len = 34;
          else if (pick < 82) len = $urandom_range(1, 17);
          else if (pick < 97) len = $urandom_range(19, 40);
          else len = 0;
          foreach (si[i]) si[i] = 8'($urandom);
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            si[10] = 8'h00;
            si[11] = 8'h00;
            si[12][7:4] = 4'h0;
          end else if (pick < 35) begin
            si[10] = 8'h0A;
            si[11] = 8'hC4;
            si[12][7:4] = 4'h4;
          end else if (pick < 45) begin
            si[14] = 8'h00;
            si[15] = 8'h00;
            si[16] = 8'h00;
          end
          add_header(b == n_blk - 1, KIND_STREAMINFO, 24'(len));
          for (int i = 0; i < len; i++)
            add_item((i < 18) ? si[i] : 8'($urandom), 1'b0, 1'b0);
        end else begin
          kind = ($urandom_range(0, 2) == 0) ? KIND_SEEKTABLE : 7'($urandom_range(1, 127));
          len = $urandom_range(0, 12);
          add_header(b == n_blk - 1, kind, 24'(len));
          repeat (len) add_item(8'($urandom), 1'b0, 1'b0);
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        cut = $urandom_range(1, build_q.size() - 1);
        while (build_q.size() > cut) void'(build_q.pop_back());
        add_item(8'($urandom), 1'b1, 1'b0);
      end
    end
    items_made += build_q.size();
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add_item(8'($urandom), 1'($urandom), 1'b0);
    foreach (build_q[i]) stim_q.push_back(build_q[i]);
  endtask

  initial begin : main
    logic [31:0] sizes [4];
    int target;
    plan = '{
      '{MARKER_0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_MARKER},
      '{8'h5A, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b1, ST_BAD_MARKER},
      '{8'hA5, 1'b0, 1'b1, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b1, ST_TRUNCATED},
      '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
      '{MARKER_0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_1, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_2, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_3, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b1, ST_TRUNCATED},
      '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
      '{MARKER_0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_1, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_2, 1'b0, 1'b0, 1'b0, ST_OK},
      '{MARKER_3, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b1, ST_SKIP_EOF}
    };
    sizes[0] = $urandom;
    sizes[1] = 32'hFFFF_FFFF;
    sizes[2] = 32'h0000_0000;
    sizes[3] = 32'($urandom_range(40, 300));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_file_size(32'd1000);
    foreach (plan[i]) stim_q.push_back(plan[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_file_size(sizes[p]);
      no_idle = (p == 1);
      if (p == 0) hold_req = 1'b1;
      target = items_made + PHASE_ITEMS;
      while (items_made < target) add_stream();
      drain();
    end

    $display("Ran %0d byte transfers and %0d result transfers under %0d file_size values,",
             bytes_taken, results_checked, settings_used);
    $display("covering good streams, marker errors, truncation, skips and restarts.");
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/flacmh_pkg.sv
src/flacmh_div.sv
src/flac_metadata_header_parser.sv
tb/tb_flac_metadata_header_parser.sv
